// ===== hw/rtl/sorot_pkg.sv =====
// Package: sector range overlap table types, constants and commands.
`default_nettype none
package sorot_pkg;

  localparam int ENTRIES  = 64;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int SECTOR_W = 48;
  localparam int COUNT_W  = 16;
  localparam int END_W    = SECTOR_W + 1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                command;
    logic [SECTOR_W-1:0] start_sector;
    logic [COUNT_W-1:0]  sector_count;
  } req_t;

  typedef struct packed {
    logic status;
    logic hit;
  } rsp_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] start;
    logic [COUNT_W-1:0]  count;
  } entry_t;

  typedef struct packed {
    logic start_eq;
    logic overlap;
  } match_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sorot_match.sv =====
// Compare of one stored range against the request: start equality and inclusive overlap.
`default_nettype none
module sorot_match
  import sorot_pkg::*;
(
  input  entry_t              ent,
  input  logic [SECTOR_W-1:0] key_start,
  input  logic [END_W-1:0]    key_end,
  output match_t              result
);

  logic [END_W-1:0] ent_end;

  // stored counts are never zero
  assign ent_end = {1'b0, ent.start} + END_W'(ent.count) - END_W'(1);

  assign result.start_eq = (ent.start == key_start);
  assign result.overlap  = ({1'b0, key_start} <= ent_end) &&
                           ({1'b0, ent.start} <= key_end);

endmodule
`default_nettype wire

// ===== hw/rtl/sector_range_overlap_table_core.sv =====
// Top level: sector range table in one RAM, scanned one entry per cycle.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_data  (req_t: command, start_sector, sector_count)
//   out_     out  out_valid/out_ready  out_data (rsp_t: status, hit)
//
// Add and clear: the result passes through the finish state into the output register.
// Remove and query: the single RAM read port delivers one entry per cycle and remove
// shifts later entries in the same pass.
// Reset empties the table (fill count to zero); RAM contents need no clearing.
// A new request is taken while a result waits; the block stalls only in its
// last step if the output register is still full.
`default_nettype none
module sector_range_overlap_table_core
  import sorot_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_valid,
  output logic       in_ready,
  input  wire  req_t in_data,
  output logic       out_valid,
  input  wire  logic out_ready,
  output rsp_t       out_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic                found_r, found_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [SECTOR_W-1:0] key_start_r, key_start_nxt;
  logic [END_W-1:0]    key_end_r, key_end_nxt;
  rsp_t                res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  rsp_t                out_data_r, out_data_nxt;

  entry_t              mem [ENTRIES];
  entry_t              rd_data_r;
  logic                rd_en;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;
  logic                scan_done;
  logic                in_fire;
  logic [COUNT_W-1:0]  req_count;
  match_t              match;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign req_count = (in_data.sector_count == '0) ? COUNT_W'(1) : in_data.sector_count;
  assign rd_en     = (state_r == ST_SCAN) && (rd_idx_r < n_r);
  assign scan_done = (state_r == ST_SCAN) && !rd_en && !pend_r;

  sorot_match u_match (
    .ent       (rd_data_r),
    .key_start (key_start_r),
    .key_end   (key_end_r),
    .result    (match)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = rd_en;
    pend_idx_nxt  = rd_idx_r[IDX_W-1:0];
    found_nxt     = found_r;
    cmd_nxt       = cmd_r;
    key_start_nxt = key_start_r;
    key_end_nxt   = key_end_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = n_r[IDX_W-1:0];
    wr_data       = rd_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt       = in_data.command;
          key_start_nxt = in_data.start_sector;
          key_end_nxt   = {1'b0, in_data.start_sector} + END_W'(req_count) - END_W'(1);
          rd_idx_nxt    = '0;
          found_nxt     = 1'b0;
          res_nxt       = '0;
          unique case (in_data.command)
            CMD_ADD: begin
              state_nxt = ST_FIN;
              if (n_r == CNT_W'(ENTRIES)) begin
                res_nxt.status = 1'b1;
              end else begin
                wr_en         = 1'b1;
                wr_addr       = n_r[IDX_W-1:0];
                wr_data.start = in_data.start_sector;
                wr_data.count = req_count;
                n_nxt         = n_r + CNT_W'(1);
              end
            end
            CMD_CLEAR: begin
              state_nxt = ST_FIN;
              n_nxt     = '0;
            end
            CMD_REMOVE, CMD_QUERY: begin
              state_nxt = ST_SCAN;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (pend_r) begin
          if (cmd_r == CMD_REMOVE) begin
            if (found_r) begin
              wr_en   = 1'b1;
              wr_addr = pend_idx_r - IDX_W'(1);
              wr_data = rd_data_r;
            end else if (match.start_eq) begin
              found_nxt = 1'b1;
            end
          end else if (match.overlap) begin
            res_nxt.hit = 1'b1;
          end
        end
        if (scan_done) begin
          state_nxt = ST_FIN;
          if ((cmd_r == CMD_REMOVE) && found_r) begin
            n_nxt = n_r - CNT_W'(1);
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    cmd_r       <= cmd_nxt;
    key_start_r <= key_start_nxt;
    key_end_r   <= key_end_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(ENTRIES))
    else $error("fill count above table size");

  a_pend_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && pend_r |-> ({1'b0, pend_idx_r} < n_r))
    else $error("scan read beyond stored ranges");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done && (cmd_r == CMD_REMOVE) && found_r |=> (n_r == $past(n_r) - CNT_W'(1)))
    else $error("remove with match did not shrink table");

  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status |-> !out_data_r.hit)
    else $error("full status together with hit");

endmodule
`default_nettype wire

// ===== tb/range_table_checker.sv =====
// Checker: predicts each sector range table result and compares it with the block output.
`timescale 1ns / 1ps
module range_table_checker
  import sorot_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  rsp_t out_data,
  output int   fail_count,
  output int   pending
);

  logic [SECTOR_W-1:0] tbl_start [ENTRIES];
  logic [COUNT_W-1:0]  tbl_count [ENTRIES];
  int                  tbl_fill = 0;
  rsp_t                expected_rsp [$];
  rsp_t                want;
  int                  rsp_seen = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 30) begin
      $display("tb: mismatch at result %0d: %s", rsp_seen, msg);
    end
    fail_count++;
  endtask

  function automatic rsp_t apply_request(input req_t r);
    rsp_t                res;
    logic [COUNT_W-1:0]  cnt;
    logic [END_W-1:0]    q_end;
    logic [END_W-1:0]    e_end;
    int                  k;
    int                  j;
    res = '0;
    cnt = (r.sector_count == '0) ? COUNT_W'(1) : r.sector_count;
    case (r.command)
      CMD_ADD: begin
        if (tbl_fill >= ENTRIES) begin
          res.status = 1'b1;
        end else begin
          tbl_start[tbl_fill] = r.start_sector;
          tbl_count[tbl_fill] = cnt;
          tbl_fill++;
        end
      end
      CMD_REMOVE: begin
        for (k = 0; k < tbl_fill; k++) begin
          if (tbl_start[k] == r.start_sector) break;
        end
        if (k < tbl_fill) begin
          for (j = k; j < tbl_fill - 1; j++) begin
            tbl_start[j] = tbl_start[j+1];
            tbl_count[j] = tbl_count[j+1];
          end
          tbl_fill--;
        end
      end
      CMD_QUERY: begin
        // ends are one bit wider so ranges near the top never wrap
        q_end = {1'b0, r.start_sector} + END_W'(cnt) - END_W'(1);
        for (k = 0; k < tbl_fill; k++) begin
          e_end = {1'b0, tbl_start[k]} + END_W'(tbl_count[k]) - END_W'(1);
          if ({1'b0, r.start_sector} <= e_end && {1'b0, tbl_start[k]} <= q_end) begin
            res.hit = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        tbl_fill = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tbl_fill = 0;
      expected_rsp.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_rsp.pop_front();
          if (out_data.status !== want.status) begin
            report_mismatch($sformatf("status got %b expected %b", out_data.status,
                                      want.status));
          end
          if (out_data.hit !== want.hit) begin
            report_mismatch($sformatf("hit got %b expected %b", out_data.hit, want.hit));
          end
        end
        rsp_seen++;
      end
      if (in_valid && in_ready) begin
        expected_rsp.push_back(apply_request(in_data));
      end
    end
    pending <= expected_rsp.size();
  end

endmodule

// ===== tb/tb_sector_range_overlap_table_core.sv =====
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module tb_sector_range_overlap_table_core
  import sorot_pkg::*;
();

  localparam int                  TOTAL_ITEMS = 630;
  localparam int                  HOLD_CYCLES = 300;
  localparam int                  DRAIN_CYCLES = 100;
  localparam int                  IDLE_LIMIT = 4000;
  localparam logic [SECTOR_W-1:0] LAST_SECTOR = '1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;
  logic hold_req;
  int   fail_count;
  int   pending;

  logic [SECTOR_W-1:0] recent_start [32];
  int                  recent_n = 0;
  int                  recent_wr = 0;
  int                  sent = 0;
  bit                  episode_idle = 1'b1;
  int                  idle_cycles = 0;

  sector_range_overlap_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  range_table_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic req_t pack_request(input cmd_t cmd, input logic [SECTOR_W-1:0] s,
                                        input logic [COUNT_W-1:0] n);
    req_t r;
    r.command      = cmd;
    r.start_sector = s;
    r.sector_count = n;
    return r;
  endfunction

  function automatic logic [SECTOR_W-1:0] pick_sector();
    int                  roll;
    logic [SECTOR_W-1:0] s;
    roll = $urandom_range(0, 99);
    if (roll < 35 && recent_n > 0) begin
      s = recent_start[$urandom_range(0, recent_n - 1)] + SECTOR_W'($urandom_range(0, 40))
          - SECTOR_W'(20);
    end else if (roll < 75) begin
      s = SECTOR_W'($urandom_range(0, 3000));
    end else if (roll < 88) begin
      s = LAST_SECTOR - SECTOR_W'($urandom_range(0, 70000));
    end else begin
      s = SECTOR_W'({$urandom, $urandom});
    end
    return s;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return COUNT_W'($urandom_range(1, 32));
    if (roll < 58) return '0;
    if (roll < 66) return '1;
    return COUNT_W'($urandom_range(0, 65535));
  endfunction

  task automatic issue_request(input req_t r, input bit idle_ok);
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    gap  = 0;
    if (idle_ok) begin
      if (roll >= 95) gap = $urandom_range(10, 40);
      else if (roll >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.command == CMD_ADD) begin
      recent_start[recent_wr] = r.start_sector;
      recent_wr = (recent_wr + 1) % 32;
      if (recent_n < 32) recent_n++;
    end
    sent++;
  endtask

  task automatic issue_random_request(input bit idle_ok);
    int                  roll;
    cmd_t                cmd;
    logic [SECTOR_W-1:0] s;
    roll = $urandom_range(0, 99);
    if (roll < 40) cmd = CMD_ADD;
    else if (roll < 60) cmd = CMD_REMOVE;
    else if (roll < 97) cmd = CMD_QUERY;
    else cmd = CMD_CLEAR;
    if (cmd == CMD_REMOVE && recent_n > 0 && $urandom_range(0, 9) < 7) begin
      s = recent_start[$urandom_range(0, recent_n - 1)];
    end else begin
      s = pick_sector();
    end
    issue_request(pack_request(cmd, s, pick_count()), idle_ok);
  endtask

  // result side back-pressure
  initial begin
    int roll;
    int left;
    bit hold_done;
    left      = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        left = HOLD_CYCLES;
      end else if (left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          out_ready <= 1'b0;
          left = $urandom_range(1, 3);
        end else if (roll < 29) begin
          out_ready <= 1'b0;
          left = $urandom_range(10, 50);
        end else if (roll < 90) begin
          out_ready <= 1'b1;
          left = $urandom_range(1, 6);
        end else begin
          out_ready <= 1'b1;
          left = $urandom_range(40, 150);
        end
      end
      @(posedge clk);
      left--;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int roll;
    bit pressure_done;
    pressure_done = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table
    issue_request(pack_request(CMD_QUERY, '0, 16'd1), 1'b1);
    issue_request(pack_request(CMD_REMOVE, '0, 16'd1), 1'b1);
    // zero count stored and queried as one sector
    issue_request(pack_request(CMD_ADD, '0, '0), 1'b1);
    issue_request(pack_request(CMD_QUERY, 48'd1, 16'd1), 1'b1);
    issue_request(pack_request(CMD_QUERY, '0, '0), 1'b1);
    // range running past the last sector, no wrap to sector zero
    issue_request(pack_request(CMD_ADD, LAST_SECTOR - 48'd2, '1), 1'b1);
    issue_request(pack_request(CMD_QUERY, LAST_SECTOR, 16'd1), 1'b1);
    issue_request(pack_request(CMD_QUERY, 48'd1, '1), 1'b1);
    // inclusive ends, duplicate starts, oldest removed first
    issue_request(pack_request(CMD_ADD, 48'd100, 16'd10), 1'b1);
    issue_request(pack_request(CMD_ADD, 48'd100, 16'd1), 1'b1);
    issue_request(pack_request(CMD_QUERY, 48'd110, 16'd5), 1'b1);
    issue_request(pack_request(CMD_QUERY, 48'd109, 16'd1), 1'b1);
    issue_request(pack_request(CMD_QUERY, 48'd90, 16'd10), 1'b1);
    issue_request(pack_request(CMD_QUERY, 48'd90, 16'd11), 1'b1);
    issue_request(pack_request(CMD_REMOVE, 48'd100, 16'd1), 1'b1);
    issue_request(pack_request(CMD_QUERY, 48'd105, 16'd1), 1'b1);
    issue_request(pack_request(CMD_REMOVE, 48'd12345, 16'd1), 1'b1);
    issue_request(pack_request(CMD_ADD, 48'hAAAA_AAAA_AAAA, 16'h5555), 1'b1);
    issue_request(pack_request(CMD_ADD, 48'h5555_5555_5555, 16'hAAAA), 1'b1);
    issue_request(pack_request(CMD_QUERY, 48'h5555_5555_5600, 16'h0001), 1'b1);
    issue_request(pack_request(CMD_CLEAR, LAST_SECTOR, '1), 1'b1);
    issue_request(pack_request(CMD_QUERY, '0, '1), 1'b1);
    issue_request(pack_request(CMD_ADD, '0, 16'd1), 1'b1);
    issue_request(pack_request(CMD_QUERY, '0, '1), 1'b1);

    while (sent < TOTAL_ITEMS) begin
      roll = $urandom_range(0, 99);
      episode_idle = ($urandom_range(0, 3) != 0);
      if (!pressure_done && sent > 200) begin
        // receiver stalls long while requests keep coming
        pressure_done = 1'b1;
        hold_req <= 1'b1;
        repeat (25) issue_random_request(1'b0);
      end else if (roll < 20) begin
        // fill the table to capacity, then probe the full table
        issue_request(pack_request(CMD_CLEAR, pick_sector(), pick_count()), episode_idle);
        repeat (ENTRIES) begin
          issue_request(pack_request(CMD_ADD, pick_sector(), pick_count()), episode_idle);
        end
        repeat (3) begin
          issue_request(pack_request(CMD_QUERY, pick_sector(), pick_count()), episode_idle);
        end
        issue_request(pack_request(CMD_ADD, pick_sector(), pick_count()), episode_idle);
        issue_request(pack_request(CMD_REMOVE, recent_start[$urandom_range(0, recent_n - 1)],
                                   pick_count()), episode_idle);
        repeat (2) begin
          issue_request(pack_request(CMD_ADD, pick_sector(), pick_count()), episode_idle);
        end
      end else begin
        repeat ($urandom_range(10, 40)) issue_random_request(episode_idle);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
